/* rtl/mas_pkg.sv */
// ----------------------------------------------------------------------------
// mas_pkg
// Shared types and constants for the matrix add/subtract/multiply core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mas_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int DIM_W  = 5;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  typedef enum logic [1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_SUM  = 2'd0,
    OP_DIFF = 2'd1,
    OP_PROD = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ELEM,
    ST_PROD,
    ST_DRAIN,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic we_a;
    logic we_b;
    logic clear;
    logic load;
    logic rd_prod;
    logic emit_err;
    logic emit_ew;
    logic emit_prod;
  } ctl_t;

  typedef struct packed {
    logic in_range;
    logic clr_last;
    logic k_last;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/mas_ctrl.sv */
// ----------------------------------------------------------------------------
// mas_ctrl
// Sequencer: clear pass, item decode, element and product read sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mas_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [1:0]      cmd,
  input  wire logic [1:0]      op,
  input  wire mas_pkg::stat_t  stat,
  output logic                 busy,
  output mas_pkg::ctl_t        ctl
);

  mas_pkg::state_t state;
  mas_pkg::state_t state_next;
  mas_pkg::cmd_t   cmd_d;
  mas_pkg::op_t    op_d;

  assign cmd_d = mas_pkg::cmd_t'(cmd);
  assign op_d  = mas_pkg::op_t'(op);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mas_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mas_pkg::ST_CLEAR: begin
        if (stat.clr_last) begin
          state_next = mas_pkg::ST_IDLE;
        end
      end
      mas_pkg::ST_IDLE: begin
        if (start && cmd_d == mas_pkg::CMD_READ && stat.in_range) begin
          if (op_d == mas_pkg::OP_PROD) begin
            state_next = mas_pkg::ST_PROD;
          end else if (op_d == mas_pkg::OP_SUM || op_d == mas_pkg::OP_DIFF) begin
            state_next = mas_pkg::ST_ELEM;
          end
        end
      end
      mas_pkg::ST_ELEM:  state_next = mas_pkg::ST_IDLE;
      mas_pkg::ST_PROD: begin
        if (stat.k_last) begin
          state_next = mas_pkg::ST_DRAIN;
        end
      end
      mas_pkg::ST_DRAIN: state_next = mas_pkg::ST_FINAL;
      mas_pkg::ST_FINAL: state_next = mas_pkg::ST_IDLE;
      default:           state_next = mas_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    unique case (state)
      mas_pkg::ST_CLEAR: ctl.clear = 1'b1;
      mas_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (cmd_d)
            mas_pkg::CMD_WRITE_A: begin
              ctl.we_a     = stat.in_range;
              ctl.emit_err = !stat.in_range;
            end
            mas_pkg::CMD_WRITE_B: begin
              ctl.we_b     = stat.in_range;
              ctl.emit_err = !stat.in_range;
            end
            mas_pkg::CMD_READ: begin
              if (!stat.in_range || op_d == mas_pkg::OP_NONE) begin
                ctl.emit_err = 1'b1;
              end else begin
                ctl.load = 1'b1;
              end
            end
            mas_pkg::CMD_NONE: ;
            default: ;
          endcase
        end
      end
      mas_pkg::ST_ELEM:  ctl.emit_ew = 1'b1;
      mas_pkg::ST_PROD:  ctl.rd_prod = 1'b1;
      mas_pkg::ST_DRAIN: ;
      mas_pkg::ST_FINAL: ctl.emit_prod = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/mas_dp.sv */
// ----------------------------------------------------------------------------
// mas_dp
// Datapath: A and B element memories, dimension register, range check,
// multiply-accumulate pipeline and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mas_dp #(
  parameter int MAX_DIM = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [mas_pkg::DIM_W-1:0]       cfg_data,
  input  wire logic [mas_pkg::IDX_W-1:0]       row,
  input  wire logic [mas_pkg::IDX_W-1:0]       col,
  input  wire logic signed [mas_pkg::DATA_W-1:0] value,
  input  wire logic [1:0]                      op,
  input  wire mas_pkg::ctl_t                   ctl,
  output mas_pkg::stat_t                       stat,
  output logic signed [mas_pkg::DATA_W-1:0]    result,
  output logic                                 status,
  output logic                                 done
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = mas_pkg::DATA_W;
  localparam int KW    = mas_pkg::DIM_W;

  function automatic logic [AW-1:0] elem_addr(input logic [KW-1:0] r,
                                               input logic [KW-1:0] c);
    logic [31:0] wide;
    wide = 32'(r) * 32'(MAX_DIM) + 32'(c);
    return wide[AW-1:0];
  endfunction

  logic [DW-1:0] mem_a [DEPTH];
  logic [DW-1:0] mem_b [DEPTH];

  logic [KW-1:0] dim;
  logic [KW-1:0] n;
  logic [AW-1:0] clr_cnt;
  logic [KW-1:0] k;
  logic [KW-1:0] row_q;
  logic [KW-1:0] col_q;
  mas_pkg::op_t  op_q;
  logic [DW-1:0] rd_a;
  logic [DW-1:0] rd_b;
  logic [DW-1:0] prod;
  logic [DW-1:0] acc;
  logic          data_v;
  logic          prod_v;

  logic [KW-1:0] row_x;
  logic [KW-1:0] col_x;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;

  always_comb begin
    if (32'(dim) > MAX_DIM) begin
      n = KW'(MAX_DIM);
    end else begin
      n = dim;
    end
  end

  assign row_x   = {1'b0, row};
  assign col_x   = {1'b0, col};
  assign in_addr = elem_addr(row_x, col_x);

  assign stat.in_range = (row_x < n) && (col_x < n);
  assign stat.clr_last = (clr_cnt == AW'(DEPTH - 1));
  assign stat.k_last   = (k == n - KW'(1));

  assign waddr   = ctl.clear ? clr_cnt : in_addr;
  assign wdata   = ctl.clear ? '0 : DW'(value);
  assign raddr_a = ctl.rd_prod ? elem_addr(row_q, k) : in_addr;
  assign raddr_b = ctl.rd_prod ? elem_addr(k, col_q) : in_addr;

  always_ff @(posedge clk) begin
    if (ctl.we_a || ctl.clear) begin
      mem_a[waddr] <= wdata;
    end
    rd_a <= mem_a[raddr_a];
  end

  always_ff @(posedge clk) begin
    if (ctl.we_b || ctl.clear) begin
      mem_b[waddr] <= wdata;
    end
    rd_b <= mem_b[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dim     <= mas_pkg::DIM_RESET;
      clr_cnt <= '0;
      data_v  <= 1'b0;
      prod_v  <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (cfg_we) begin
        dim <= cfg_data;
      end
      if (ctl.clear) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      data_v <= ctl.rd_prod;
      prod_v <= data_v;
      done   <= ctl.emit_err || ctl.emit_ew || ctl.emit_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      row_q <= row_x;
      col_q <= col_x;
      op_q  <= mas_pkg::op_t'(op);
      k     <= '0;
    end else if (ctl.rd_prod) begin
      k <= k + KW'(1);
    end
  end

  // multiply stage, then accumulate
  always_ff @(posedge clk) begin
    prod <= DW'(rd_a * rd_b);
    if (ctl.load) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + prod;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_err) begin
      result <= '0;
      status <= 1'b1;
    end else if (ctl.emit_ew) begin
      status <= 1'b0;
      if (op_q == mas_pkg::OP_DIFF) begin
        result <= signed'(rd_a - rd_b);
      end else begin
        result <= signed'(rd_a + rd_b);
      end
    end else if (ctl.emit_prod) begin
      result <= signed'(acc + prod);
      status <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/matrix_add_sub_mul_core.sv */
// ----------------------------------------------------------------------------
// matrix_add_sub_mul_core
// Two square integer matrices A and B with element writes and element reads
// of A+B, A-B or A*B, all wrapping modulo 2^32.
//
//   channel  | control        | data
//   ---------+----------------+----------------------------------
//   input    | start / busy   | cmd, row, col, value, op
//   result   | done (strobe)  | result, status
//   config   | cfg_we         | cfg_data (dim)
//
// A word is taken at a clock edge with start high and busy low.
// Writes, errors and unused commands are taken in IDLE; busy stays low.
// Sum/difference reads: busy in ELEM; done and result are registered from it.
// Product reads (n = effective dim): busy in PROD, DRAIN and FINAL; one MAC
// term per cycle over n terms through a single read port on each memory,
// then multiply and add stages. After reset a clearing pass zeroes both
// memories with busy high. done lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module matrix_add_sub_mul_core #(
  parameter int MAX_DIM = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [4:0]           cfg_data,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           cmd,
  input  wire logic [3:0]           row,
  input  wire logic [3:0]           col,
  input  wire logic signed [31:0]   value,
  input  wire logic [1:0]           op,
  output logic                      done,
  output logic signed [31:0]        result,
  output logic                      status
);

  mas_pkg::ctl_t  ctl;
  mas_pkg::stat_t stat;

  mas_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .op    (op),
    .stat  (stat),
    .busy  (busy),
    .ctl   (ctl)
  );

  mas_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .row      (row),
    .col      (col),
    .value    (value),
    .op       (op),
    .ctl      (ctl),
    .stat     (stat),
    .result   (result),
    .status   (status),
    .done     (done)
  );

endmodule

`default_nettype wire
